// ===== sv/calr_pkg.sv =====
// Package for the contour arc-length resampler: widths, defaults, shared types.
// No dependencies.
package calr_pkg;
  localparam int COORD_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF = 8;
  localparam int SPACING_BITS = 8;
  localparam logic [SPACING_BITS-1:0] SPACING_RESET = 8'd32;
  localparam logic [SPACING_BITS-1:0] SPACING_MIN = 8'd24;
  localparam int MAX_OUT = 64;
  localparam int CNT_BITS = 7;

  typedef struct packed {
    logic load;      // capture a request and start the segment math
    logic root_step; // one step of the square root
    logic div_start; // start a placement division
    logic div_step;  // one step of the placement divider
    logic emit;      // present a centre to the output register
    logic advance;   // move to the next position
    logic finish;    // commit carried length and previous vertex
  } calr_cmd_t;

  typedef struct packed {
    logic root_done;
    logic div_done;
    logic more;      // another centre fits on this segment
    logic is_start;
    logic out_free;
  } calr_stat_t;
endpackage

// ===== sv/calr_if.sv =====
// Valid/ready stream interfaces for the resampler.
// Depends on calr_pkg.
interface calr_in_if #(parameter int COORD_BITS = calr_pkg::COORD_BITS_DEF);
  logic valid;
  logic ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic starts_contour;
  modport source (output valid, point_x, point_y, starts_contour, input ready);
  modport sink (input valid, point_x, point_y, starts_contour, output ready);
endinterface

interface calr_out_if #(parameter int COORD_BITS = calr_pkg::COORD_BITS_DEF);
  logic valid;
  logic ready;
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic last_of_run;
  modport source (output valid, center_x, center_y, last_of_run, input ready);
  modport sink (input valid, center_x, center_y, last_of_run, output ready);
endinterface

// ===== sv/contour_arc_length_resampler.sv =====
// Top level of the contour arc-length resampler.
// Depends on calr_pkg, calr_if, calr_ctrl, calr_dp.
//
// Usage: vertex requests enter on the in channel (point_x, point_y,
// starts_contour); window centres leave on the out channel (center_x,
// center_y, last_of_run). A vertex that starts a contour gives one centre,
// its own point, once the output register is free. Any other vertex runs a
// bit-serial square root and then a check; each centre then takes a
// bit-serial division, the two axes divided side by side, plus an emit
// step and a check. Only one vertex is in flight: in.ready is high while
// the controller is idle.
// The output register holds a centre until out.ready; while it waits the
// controller holds before the next emit, so a stalled receiver stalls the
// block and nothing is dropped.
// Reset (rst, synchronous) clears the previous vertex to (0,0), the carried
// length to zero and the spacing to 32. Write cfg_we/cfg_data only while idle.
module contour_arc_length_resampler #(
  parameter int COORD_BITS = calr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS = calr_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  calr_in_if.sink in,
  calr_out_if.source out,
  input  logic cfg_we,
  input  logic [calr_pkg::SPACING_BITS-1:0] cfg_data
);
  logic [calr_pkg::SPACING_BITS-1:0] spacing;
  calr_pkg::calr_cmd_t cmd;
  calr_pkg::calr_stat_t stat;
  logic in_fire;

  // hold the spacing register; values below the minimum are raised in the datapath
  always_ff @(posedge clk) begin
    if (rst) spacing <= calr_pkg::SPACING_RESET;
    else if (cfg_we) spacing <= cfg_data;
  end

  assign in_fire = in.valid && in.ready;

  calr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_ready(in.ready),
    .stat(stat), .cmd(cmd)
  );

  calr_dp #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst),
    .in_x(in.point_x), .in_y(in.point_y), .in_start(in.starts_contour),
    .spacing(spacing), .cmd(cmd), .stat(stat),
    .out_valid(out.valid), .out_ready(out.ready),
    .out_x(out.center_x), .out_y(out.center_y), .out_last(out.last_of_run)
  );
endmodule

// ===== sv/calr_ctrl.sv =====
// Controller state machine of the resampler.
// Depends on calr_pkg.
module calr_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  output logic in_ready,
  input  calr_pkg::calr_stat_t stat,
  output calr_pkg::calr_cmd_t cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROOT = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_START = 3'd5;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = stat.is_start ? S_START : S_ROOT;
        end
      end
      S_START: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (stat.root_done) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.more) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.advance = 1'b1;
          state_next = S_CHECK;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) cmd.emit |-> stat.out_free)
    else $error("centre emitted into a full output register");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_fire) |=> !in_ready)
    else $error("request taken while idle left the controller idle");
  assert property (@(posedge clk) disable iff (rst) cmd.load |-> in_ready)
    else $error("load outside idle");
endmodule

// ===== sv/calr_dp.sv =====
// Datapath of the resampler: square root, placement divider, output register.
// Depends on calr_pkg.
module calr_dp #(
  parameter int COORD_BITS = calr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS = calr_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic [COORD_BITS-1:0] in_x,
  input  logic [COORD_BITS-1:0] in_y,
  input  logic in_start,
  input  logic [calr_pkg::SPACING_BITS-1:0] spacing,
  input  calr_pkg::calr_cmd_t cmd,
  output calr_pkg::calr_stat_t stat,
  output logic out_valid,
  input  logic out_ready,
  output logic [COORD_BITS-1:0] out_x,
  output logic [COORD_BITS-1:0] out_y,
  output logic out_last
);
  localparam int CB = COORD_BITS;
  localparam int LB = CB + 1 + FRAC_BITS;       // segment length in fixed point
  localparam int SQB = 2 * LB;                  // radicand width
  localparam int RSTEPS = LB;
  localparam int RCB = $clog2(RSTEPS + 1);
  localparam int CLB = calr_pkg::SPACING_BITS + FRAC_BITS; // carried length
  localparam int PB = CLB + calr_pkg::CNT_BITS + 1;        // position
  localparam int NB = CB + LB + PB + 3;                     // numerator
  localparam int QB = CB;                                   // quotient never exceeds a coordinate
  localparam int DB = LB + 1;                               // 2*len
  localparam int DCB = $clog2(NB + 1);

  logic [CB-1:0] prev_x, prev_y, cur_x, cur_y;
  logic [CLB-1:0] carried;
  logic [CB:0] adx, ady;
  logic sgx, sgy;
  logic in_start_r;
  logic [SQB-1:0] rad, rem_r;
  logic [LB-1:0] root;
  logic [RCB-1:0] rcnt;
  logic [CLB-1:0] wfix;
  logic [calr_pkg::SPACING_BITS-1:0] wsel;
  logic [PB-1:0] pos;
  logic [PB:0] remaining;
  logic [calr_pkg::CNT_BITS-1:0] n;
  logic [2*CB+1:0] sqx, sqy;
  logic [2*CB+2:0] sumsq;

  // placement divider: one numerator per axis, shared step counter
  logic [NB-1:0] nx, ny;
  logic [QB-1:0] qx, qy;
  logic [NB-1:0] rx, ry;
  logic [DCB-1:0] dcnt;
  logic zero_len;
  logic next_more;

  assign wsel = (spacing < calr_pkg::SPACING_MIN) ? calr_pkg::SPACING_MIN : spacing;
  assign wfix = {wsel, {FRAC_BITS{1'b0}}};

  assign sqx = adx * adx;
  assign sqy = ady * ady;
  assign sumsq = {1'b0, sqx} + {1'b0, sqy};

  // restoring square root, one bit a step
  logic [SQB-1:0] trial;
  logic [SQB-1:0] rad_shift;
  always_comb begin
    rad_shift = {rem_r[SQB-3:0], rad[SQB-1 -: 2]};
    trial = {{(SQB-LB-2){1'b0}}, root, 2'b01};
  end

  function automatic logic [NB-1:0] numer(input logic [CB-1:0] b, input logic s,
      input logic [CB:0] a, input logic [PB-1:0] p, input logic [LB-1:0] l);
    logic [CB+LB-1:0] blp;
    logic [CB+PB:0] app;
    logic [NB-1:0] bl, ap, t;
    begin
      blp = b * l;
      app = a * p;
      bl = NB'(blp);
      ap = NB'(app);
      t = (bl << 1) + NB'(l);
      if (s) t = (t >= (ap << 1)) ? t - (ap << 1) : '0;
      else t = t + (ap << 1);
      numer = t;
    end
  endfunction

  logic [DB-1:0] den;
  assign den = {root, 1'b0};

  logic [NB-1:0] rxs, rys;
  assign rxs = {rx[NB-2:0], nx[NB-1]};
  assign rys = {ry[NB-2:0], ny[NB-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0;
      prev_y <= '0;
      carried <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.load) begin
        cur_x <= in_x;
        cur_y <= in_y;
        in_start_r <= in_start;
        sgx <= in_x < prev_x;
        sgy <= in_y < prev_y;
        adx <= (in_x < prev_x) ? {1'b0, prev_x - in_x} : {1'b0, in_x - prev_x};
        ady <= (in_y < prev_y) ? {1'b0, prev_y - in_y} : {1'b0, in_y - prev_y};
        rad <= '0;
        rem_r <= '0;
        root <= '0;
        rcnt <= '0;
        n <= '0;
        if (carried > wfix) carried <= wfix;
      end
      if (cmd.root_step) begin
        if (rcnt == '0) begin
          // radicand = (dx^2 + dy^2) << 2F
          rad <= SQB'(sumsq) << (2 * FRAC_BITS);
          rcnt <= RCB'(1);
          pos <= PB'(wfix - carried);
          remaining <= '0;
        end else begin
          rad <= rad << 2;
          if (rad_shift >= trial) begin
            rem_r <= rad_shift - trial;
            root <= {root[LB-2:0], 1'b1};
          end else begin
            rem_r <= rad_shift;
            root <= {root[LB-2:0], 1'b0};
          end
          rcnt <= rcnt + RCB'(1);
          if (rcnt == RCB'(RSTEPS))
            remaining <= (PB+1)'(carried) + (PB+1)'({root[LB-2:0], (rad_shift >= trial)});
        end
      end
      if (cmd.div_start) begin
        nx <= numer(prev_x, sgx, adx, pos, root);
        ny <= numer(prev_y, sgy, ady, pos, root);
        rx <= '0;
        ry <= '0;
        qx <= '0;
        qy <= '0;
      end
      if (cmd.div_step) begin
        // long division: shift out the bits above the quotient first
        nx <= nx << 1;
        ny <= ny << 1;
        if (rxs >= NB'(den)) begin
          rx <= rxs - NB'(den);
          qx <= {qx[QB-2:0], 1'b1};
        end else begin
          rx <= rxs;
          qx <= {qx[QB-2:0], 1'b0};
        end
        if (rys >= NB'(den)) begin
          ry <= rys - NB'(den);
          qy <= {qy[QB-2:0], 1'b1};
        end else begin
          ry <= rys;
          qy <= {qy[QB-2:0], 1'b0};
        end
      end
      if (cmd.emit) begin
        if (in_start_r) begin
          out_x <= cur_x;
          out_y <= cur_y;
          out_last <= 1'b1;
        end else begin
          out_x <= zero_len ? prev_x : qx;
          out_y <= zero_len ? prev_y : qy;
          out_last <= !next_more;
        end
      end
      if (cmd.advance) begin
        pos <= pos + PB'(wfix);
        remaining <= remaining - (PB+1)'(wfix);
        n <= n + calr_pkg::CNT_BITS'(1);
      end
      if (cmd.finish) begin
        prev_x <= cur_x;
        prev_y <= cur_y;
        if (in_start_r) carried <= '0;
        else if (remaining >= (PB+1)'(wfix)) carried <= '0;
        else carried <= CLB'(remaining);
      end
    end
  end

  // numerator is fully consumed once it has been shifted NB times; the
  // quotient is below 2^QB so the top NB-QB steps give zero bits
  always_ff @(posedge clk) begin
    if (cmd.div_start) dcnt <= '0;
    else if (cmd.div_step) dcnt <= dcnt + DCB'(1);
  end

  assign zero_len = (root == '0);
  assign next_more = (remaining - (PB+1)'(wfix) >= (PB+1)'(wfix)) &&
                     (n != calr_pkg::CNT_BITS'(calr_pkg::MAX_OUT - 1));

  assign stat.root_done = (rcnt == RCB'(RSTEPS));
  assign stat.div_done = (dcnt == DCB'(NB - 1));
  assign stat.more = (remaining >= (PB+1)'(wfix)) &&
                     (n != calr_pkg::CNT_BITS'(calr_pkg::MAX_OUT));
  assign stat.is_start = in_start;
  assign stat.out_free = !out_valid || out_ready;
endmodule

// ===== dv/tb_calr_if.sv =====
`timescale 1ns / 100ps
// Stall-control interface shared by the resampler testbench stimulus tasks.
// Depends on nothing.
interface tb_calr_knobs_if;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_recv;
endinterface

// ===== dv/tb_contour_arc_length_resampler.sv =====
`timescale 1ns / 100ps
// Testbench for contour_arc_length_resampler: drives vertex requests, predicts the
// resampled window centres and checks each one. Depends on calr_pkg, calr_if, tb_calr_if.
module tb_contour_arc_length_resampler;
  localparam int CB = calr_pkg::COORD_BITS_DEF;
  localparam int FB = calr_pkg::FRAC_BITS_DEF;
  localparam int STUCK_LIMIT = 20000;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic          last;
  } centre_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [calr_pkg::SPACING_BITS-1:0] cfg_data = '0;

  calr_in_if  #(.COORD_BITS(CB)) vin();
  calr_out_if #(.COORD_BITS(CB)) vout();
  tb_calr_knobs_if knobs();

  contour_arc_length_resampler #(.COORD_BITS(CB), .FRAC_BITS(FB)) DUT (
    .clk(clk), .rst(rst), .in(vin.sink), .out(vout.source),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: mirrors the block's previous vertex, carry and spacing.
  logic [calr_pkg::SPACING_BITS-1:0] spacing_reg;
  longint unsigned prev_x, prev_y, carry_len;
  centre_t expected_centres[$];
  int errors = 0;
  int unsigned stuck_cycles = 0;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Round base + delta*pos/len to nearest, ties up.
  function automatic logic [CB-1:0] place_coord(longint unsigned base, longint delta,
                                                longint unsigned pos, longint unsigned len);
    longint num;
    if (len == 0) return base[CB-1:0];
    num = 2 * longint'(base) * longint'(len) + 2 * delta * longint'(pos) + longint'(len);
    if (num < 0) num = 0;
    return CB'(longint'(num) / longint'(2 * len));
  endfunction

  // Append one centre to the expectations.
  function automatic void queue_centre(centre_t c);
    expected_centres.insert(expected_centres.size(), c);
  endfunction

  // Work out the centres one vertex produces and queue them.
  task automatic predict_centres(logic [CB-1:0] px, logic [CB-1:0] py, logic first);
    longint unsigned w, wfix, len, remaining, pos;
    longint dx, dy;
    int n;
    centre_t c;
    if (first) begin
      c.x = px;
      c.y = py;
      c.last = 1'b1;
      queue_centre(c);
      prev_x = px;
      prev_y = py;
      carry_len = 0;
      return;
    end
    w = (spacing_reg < calr_pkg::SPACING_MIN) ? calr_pkg::SPACING_MIN : spacing_reg;
    wfix = w << FB;
    // spacing lowered mid-contour: clamp the carry
    if (carry_len > wfix) carry_len = wfix;
    dx = longint'(px) - longint'(prev_x);
    dy = longint'(py) - longint'(prev_y);
    len = isqrt(longint'(dx * dx + dy * dy) << (2 * FB));
    remaining = carry_len + len;
    pos = wfix - carry_len;
    n = 0;
    while (remaining >= wfix && n < calr_pkg::MAX_OUT) begin
      c.x = place_coord(prev_x, dx, pos, len);
      c.y = place_coord(prev_y, dy, pos, len);
      c.last = 1'b0;
      queue_centre(c);
      n++;
      pos += wfix;
      remaining -= wfix;
    end
    // surplus beyond 64 centres is dropped
    carry_len = (remaining >= wfix) ? 0 : remaining;
    if (n > 0) expected_centres[$].last = 1'b1;
    prev_x = px;
    prev_y = py;
  endtask

  // Receiver: random stalls, plus a forced hold-off when asked.
  initial begin
    vout.ready <= 1'b0;
    forever begin
      @(posedge clk);
      vout.ready <= !knobs.hold_recv && ($urandom_range(99) >= knobs.recv_stall_pct);
    end
  end

  // Compare every accepted centre against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && vout.valid && vout.ready) begin
      if (expected_centres.size() == 0) begin
        $error("unexpected centre x=%0d y=%0d", vout.center_x, vout.center_y);
        errors++;
      end else begin
        centre_t e;
        e = expected_centres.pop_front();
        if (vout.center_x !== e.x) begin
          $error("center_x expected %0d got %0d", e.x, vout.center_x);
          errors++;
        end
        if (vout.center_y !== e.y) begin
          $error("center_y expected %0d got %0d", e.y, vout.center_y);
          errors++;
        end
        if (vout.last_of_run !== e.last) begin
          $error("last_of_run expected %0d got %0d", e.last, vout.last_of_run);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no request and no centre is accepted.
  always @(posedge clk) begin
    if ((vin.valid && vin.ready) || (vout.valid && vout.ready) || rst)
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("contour_arc_length_resampler: mismatch");
      $finish;
    end
  end

  // Offer one vertex request, after a random idle wait, once the previous one was taken
  // (the block is busy with that one first); hold it until the block takes it.
  task automatic send_vertex(logic [CB-1:0] px, logic [CB-1:0] py, logic first);
    while ($urandom_range(99) < knobs.send_idle_pct) @(posedge clk);
    @(posedge clk);
    vin.valid <= 1'b1;
    vin.point_x <= px;
    vin.point_y <= py;
    vin.starts_contour <= first;
    do @(posedge clk); while (!vin.ready);
    predict_centres(px, py, first);
    vin.valid <= 1'b0;
  endtask

  // Wait for every centre to arrive, then for any vertex that yields none to finish.
  task automatic drain();
    while (expected_centres.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_spacing(logic [calr_pkg::SPACING_BITS-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    spacing_reg = v;
  endtask

  // Extremes, no-contour-yet vertex, zero-length segment, long segments.
  task automatic test_directed();
    send_vertex(10'd100, 10'd0, 1'b0);     // measures from the reset vertex (0,0)
    send_vertex(10'd0, 10'd0, 1'b1);
    send_vertex(10'd1023, 10'd1023, 1'b0);
    send_vertex(10'd1023, 10'd1023, 1'b0); // zero-length segment
    send_vertex(10'd0, 10'd1023, 1'b0);
    send_vertex(10'd1023, 10'd0, 1'b1);
    send_vertex(10'd0, 10'd1023, 1'b0);
    write_spacing(8'd0);                   // below minimum: acts as 24
    send_vertex(10'd0, 10'd0, 1'b0);       // full-height segment
    send_vertex(10'd1023, 10'd0, 1'b0);
    send_vertex(10'd1023, 10'd1023, 1'b0);
    send_vertex(10'd0, 10'd0, 1'b0);       // diagonal, 60 centres
    write_spacing(8'd255);
    send_vertex(10'd200, 10'd0, 1'b0);     // builds a large carry
    write_spacing(8'd24);                  // spacing lowered mid-contour
    send_vertex(10'd210, 10'd5, 1'b0);
    send_vertex(10'd512, 10'd512, 1'b1);
    send_vertex(10'd513, 10'd512, 1'b0);   // yields nothing
    write_spacing(8'd23);
    send_vertex(10'd600, 10'd700, 1'b0);
  endtask

  // Mostly contours of short random steps, some long jumps and fresh starts.
  task automatic test_random(int count);
    logic [CB-1:0] x, y;
    x = CB'($urandom);
    y = CB'($urandom);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: send_vertex(CB'($urandom), CB'($urandom), 1'b1);
        1, 2: send_vertex(CB'($urandom), CB'($urandom), 1'b0);
        default: begin
          x = prev_x[CB-1:0] + CB'($urandom_range(160)) - CB'(80);
          y = prev_y[CB-1:0] + CB'($urandom_range(160)) - CB'(80);
          send_vertex(x, y, 1'b0);
        end
      endcase
    end
  endtask

  // Hold the receiver off for a counted stretch while vertices keep coming,
  // so the block backs up and stalls its input.
  task automatic test_backpressure();
    knobs.hold_recv = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        knobs.hold_recv = 1'b0;
      end
      begin
        send_vertex(10'd10, 10'd10, 1'b1);
        send_vertex(10'd300, 10'd300, 1'b0);
        send_vertex(10'd20, 10'd300, 1'b0);  // waits until the receiver resumes
      end
    join
    drain();  // sender pauses until everything has come back
  endtask

  initial begin
    vin.valid <= 1'b0;
    vin.point_x <= '0;
    vin.point_y <= '0;
    vin.starts_contour <= 1'b0;
    knobs.send_idle_pct = 0;
    knobs.recv_stall_pct = 0;
    knobs.hold_recv = 1'b0;
    spacing_reg = calr_pkg::SPACING_RESET;
    prev_x = 0;
    prev_y = 0;
    carry_len = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_backpressure();
    write_spacing(8'd32);
    test_random(100);
    knobs.send_idle_pct = 64;
    write_spacing(8'd255);
    test_random(100);
    knobs.send_idle_pct = 0;
    knobs.recv_stall_pct = 64;
    write_spacing(8'd24);
    test_random(100);
    knobs.send_idle_pct = 19;
    knobs.recv_stall_pct = 19;
    write_spacing(8'($urandom_range(24, 255)));
    test_random(100);
    drain();

    if (errors == 0 && expected_centres.size() == 0)
      $display("contour_arc_length_resampler: match");
    else
      $display("contour_arc_length_resampler: mismatch");
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/calr_pkg.sv
sv/calr_if.sv
sv/calr_ctrl.sv
sv/calr_dp.sv
sv/contour_arc_length_resampler.sv
dv/tb_calr_if.sv
dv/tb_contour_arc_length_resampler.sv
